>>> design/stack_vm_execute_unit_defines.svh
// Assertion macros shared by the stack machine execute unit RTL.
// Depends on nothing; expects signals clk and arst_n in the including module.
`ifndef STACK_VM_EXECUTE_UNIT_DEFINES_SVH
`define STACK_VM_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SVM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/svm_pkg.sv
// Package for the stack machine execute unit: opcodes, status codes and
// parameter defaults. Depends on nothing.
package svm_pkg;

	localparam int STACK_DEPTH_DEF      = 4096;
	localparam int CALL_DEPTH_DEF       = 64;
	localparam int LOCALS_PER_FRAME_DEF = 16;
	localparam int ADDRESS_BITS_DEF     = 16;

	localparam logic [4:0] OP_START    = 5'd0;
	localparam logic [4:0] OP_PUSH_ARG = 5'd1;
	localparam logic [4:0] OP_NOP      = 5'd2;
	localparam logic [4:0] OP_PUSH     = 5'd3;
	localparam logic [4:0] OP_POP      = 5'd4;
	localparam logic [4:0] OP_DUP      = 5'd5;
	localparam logic [4:0] OP_SWAP     = 5'd6;
	localparam logic [4:0] OP_LOAD     = 5'd7;
	localparam logic [4:0] OP_STORE    = 5'd8;
	localparam logic [4:0] OP_JMP      = 5'd9;
	localparam logic [4:0] OP_JNZ      = 5'd10;
	localparam logic [4:0] OP_JZ       = 5'd11;
	localparam logic [4:0] OP_CALL     = 5'd12;
	localparam logic [4:0] OP_RET      = 5'd13;
	localparam logic [4:0] OP_ADD      = 5'd14;
	localparam logic [4:0] OP_SUB      = 5'd15;
	localparam logic [4:0] OP_EQ       = 5'd16;
	localparam logic [4:0] OP_LEQ      = 5'd17;
	localparam logic [4:0] OP_GEQ      = 5'd18;
	localparam logic [4:0] OP_LT       = 5'd19;
	localparam logic [4:0] OP_GT       = 5'd20;
	localparam logic [4:0] OP_LNOT     = 5'd21;
	localparam logic [4:0] OP_HALT     = 5'd22;

	localparam logic [3:0] ST_NEXT       = 4'd0;
	localparam logic [3:0] ST_HALTED     = 4'd1;
	localparam logic [3:0] ST_STACK_UNDER = 4'd2;
	localparam logic [3:0] ST_STACK_OVER = 4'd3;
	localparam logic [3:0] ST_CALL_OVER  = 4'd4;
	localparam logic [3:0] ST_CALL_UNDER = 4'd5;
	localparam logic [3:0] ST_BAD_OPCODE = 4'd6;
	localparam logic [3:0] ST_BAD_ADDR   = 4'd7;
	localparam logic [3:0] ST_BAD_LOCAL  = 4'd8;

endpackage

>>> design/svm_if.sv
// Channel interfaces of the stack machine execute unit: instruction words,
// result words and configuration writes. Depends on nothing.
interface svm_cmd_if;
	logic        valid;
	logic        ready;
	logic [4:0]  command;
	logic [31:0] operand;
	modport source (output valid, command, operand, input ready);
	modport sink (input valid, command, operand, output ready);
endinterface

interface svm_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [15:0] next_address;
	logic [31:0] top_value;
	logic [12:0] stack_count;
	logic [6:0]  frame_depth;
	modport source (output valid, status, next_address, top_value, stack_count, frame_depth,
		input ready);
	modport sink (input valid, status, next_address, top_value, stack_count, frame_depth,
		output ready);
endinterface

interface svm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> design/stack_vm_execute_unit.sv
// Top level of the stack machine execute unit; uses svm_pkg, the channel
// interfaces in svm_if.sv, svm_ram and the assertion macros header.
//
// This unit executes one stack-machine instruction per instruction word and
// returns one result word for each. It sustains one instruction per clock
// while the result channel does not stall it: the word is accepted while the
// previous one executes, and its result is registered in the output register
// when it executes. The registered read of the stack, locals, local-written
// flags and return-address memories is issued in the accept cycle using the
// state the executing instruction is about to leave, and the read data is
// held until the accepted word executes; a write in
// that same cycle to the entry being read is forwarded. The top of the data
// stack lives in a register and the words below it in the stack memory, so
// every instruction needs one stack read and at most one stack write. The
// local-written flags are kept in a memory with one row per frame; a row is
// cleared whenever its frame is opened by start or call, and no row is read
// before its frame has been opened, so no clearing pass is needed after
// reset. code_last may only be written while no instruction is in flight.
// After reset the unit is stopped until a start instruction arrives.
`include "stack_vm_execute_unit_defines.svh"

module stack_vm_execute_unit #(
	parameter int STACK_DEPTH      = svm_pkg::STACK_DEPTH_DEF,
	parameter int CALL_DEPTH       = svm_pkg::CALL_DEPTH_DEF,
	parameter int LOCALS_PER_FRAME = svm_pkg::LOCALS_PER_FRAME_DEF,
	parameter int ADDRESS_BITS     = svm_pkg::ADDRESS_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	svm_cmd_if.sink  instr,
	svm_res_if.source result,
	svm_cfg_if.sink  cfg
);

	localparam int SA  = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int FB  = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
	localparam int DW  = $clog2(CALL_DEPTH + 1);
	localparam int LB  = (LOCALS_PER_FRAME > 1) ? $clog2(LOCALS_PER_FRAME) : 1;
	localparam int LOC_DEPTH = CALL_DEPTH << LB;
	localparam int AW  = ADDRESS_BITS;
	localparam int LPF = LOCALS_PER_FRAME;

	// Architectural state.
	logic [15:0]           code_last_q;
	logic [AW-1:0]         ip_q;
	logic [SPW-1:0]        sp_q;
	logic [31:0]           top_q;
	logic [DW-1:0]         depth_q;
	logic                  stopped_q;

	// Execute stage.
	logic        valid_s1;
	logic [4:0]  cmd_s1;
	logic [31:0] opnd_s1;

	// Output register.
	logic        out_valid_q;
	logic [3:0]  out_status_q;
	logic [15:0] out_addr_q;
	logic [31:0] out_top_q;
	logic [12:0] out_count_q;
	logic [6:0]  out_depth_q;

	// Forwarding of same-cycle writes into the read just issued.
	logic        st_byp_q, loc_byp_q, ret_byp_q, flg_byp_q;
	logic [31:0] st_byp_data_q, loc_byp_data_q;
	logic [AW-1:0] ret_byp_data_q;
	logic [LPF-1:0] flg_byp_data_q;

	logic out_free, fire, accept;
	assign out_free = !out_valid_q || result.ready;
	assign fire     = valid_s1 && out_free;
	assign instr.ready = !valid_s1 || out_free;
	assign accept   = instr.valid && instr.ready;
	assign cfg.ready = 1'b1;

	// Memory ports.
	logic              st_we;
	logic [SA-1:0]     st_wa, st_ra;
	logic [31:0]       st_wd, st_rd;
	logic              loc_we;
	logic [FB+LB-1:0]  loc_wa, loc_ra;
	logic [31:0]       loc_wd, loc_rd;
	logic              ret_we;
	logic [FB-1:0]     ret_wa, ret_ra;
	logic [AW-1:0]     ret_wd, ret_rd;
	logic              flg_we;
	logic [FB-1:0]     flg_wa, flg_ra;
	logic [LPF-1:0]    flg_wd, flg_rd;

	logic [31:0]   second, local_val;
	logic [AW-1:0] ret_val;
	logic [LPF-1:0] flg_row;
	assign second  = st_byp_q ? st_byp_data_q : st_rd;
	assign ret_val = ret_byp_q ? ret_byp_data_q : ret_rd;
	assign flg_row = flg_byp_q ? flg_byp_data_q : flg_rd;

	// Next-state decision for the instruction in the execute stage.
	logic [AW-1:0]  n_ip;
	logic [SPW-1:0] n_sp;
	logic [31:0]    n_top;
	logic [DW-1:0]  n_depth;
	logic           n_stopped;
	logic [3:0]     status;

	logic [AW-1:0]  ip_p1, ip_p2, ip_rel;
	logic [SPW-1:0] sp_m1;
	logic [DW-1:0]  depth_m1;
	logic [LB-1:0]  slot;
	logic           sp_empty, sp_full, sp_lt2, depth_zero;

	assign ip_p1    = ip_q + AW'(1);
	assign ip_p2    = ip_q + AW'(2);
	assign ip_rel   = ip_q + opnd_s1[AW-1:0];
	assign sp_m1    = sp_q - SPW'(1);
	assign depth_m1 = depth_q - DW'(1);
	assign slot     = opnd_s1[LB-1:0];
	assign sp_empty = (sp_q == '0);
	assign sp_full  = (sp_q == SPW'(STACK_DEPTH));
	assign sp_lt2   = (sp_q < SPW'(2));
	assign depth_zero = (depth_q == '0);
	assign local_val = flg_row[slot]
		? (loc_byp_q ? loc_byp_data_q : loc_rd) : 32'hFFFF_FFFF;

	always_comb begin
		n_ip = ip_q;
		n_sp = sp_q;
		n_top = top_q;
		n_depth = depth_q;
		n_stopped = stopped_q;
		status = svm_pkg::ST_NEXT;
		st_we = 1'b0;
		st_wa = sp_m1[SA-1:0];
		st_wd = top_q;
		loc_we = 1'b0;
		loc_wa = {depth_m1[FB-1:0], slot};
		loc_wd = top_q;
		ret_we = 1'b0;
		ret_wa = depth_q[FB-1:0];
		ret_wd = ip_p2;
		flg_we = 1'b0;
		flg_wa = depth_q[FB-1:0];
		flg_wd = '0;
		if (cmd_s1 == svm_pkg::OP_START) begin
			n_ip = opnd_s1[AW-1:0];
			n_sp = '0;
			n_depth = DW'(1);
			n_stopped = 1'b0;
			ret_we = 1'b1;
			ret_wa = '0;
			ret_wd = '0;
			flg_we = 1'b1;
			flg_wa = '0;
		end else if (stopped_q) begin
			status = svm_pkg::ST_HALTED;
		end else if (cmd_s1 == svm_pkg::OP_PUSH_ARG) begin
			if (sp_full) begin
				status = svm_pkg::ST_STACK_OVER;
			end else begin
				st_we = !sp_empty;
				n_top = opnd_s1;
				n_sp = sp_q + SPW'(1);
			end
		end else if (cmd_s1 > svm_pkg::OP_HALT) begin
			status = svm_pkg::ST_BAD_OPCODE;
		end else if (32'(ip_q) > 32'(code_last_q)) begin
			status = svm_pkg::ST_BAD_ADDR;
		end else begin
			case (cmd_s1)
				svm_pkg::OP_NOP: begin
					n_ip = ip_p1;
				end
				svm_pkg::OP_PUSH: begin
					if (sp_full) begin
						status = svm_pkg::ST_STACK_OVER;
					end else begin
						st_we = !sp_empty;
						n_top = opnd_s1;
						n_sp = sp_q + SPW'(1);
						n_ip = ip_p2;
					end
				end
				svm_pkg::OP_POP: begin
					if (sp_empty) begin
						status = svm_pkg::ST_STACK_UNDER;
					end else begin
						n_top = second;
						n_sp = sp_m1;
						n_ip = ip_p1;
					end
				end
				svm_pkg::OP_DUP: begin
					if (sp_empty) begin
						status = svm_pkg::ST_STACK_UNDER;
					end else if (sp_full) begin
						status = svm_pkg::ST_STACK_OVER;
					end else begin
						st_we = 1'b1;
						n_sp = sp_q + SPW'(1);
						n_ip = ip_p1;
					end
				end
				svm_pkg::OP_SWAP: begin
					if (sp_lt2) begin
						status = svm_pkg::ST_STACK_UNDER;
					end else begin
						st_we = 1'b1;
						st_wa = SA'(sp_q - SPW'(2));
						n_top = second;
						n_ip = ip_p1;
					end
				end
				svm_pkg::OP_LOAD, svm_pkg::OP_STORE: begin
					if (depth_zero) begin
						status = svm_pkg::ST_CALL_UNDER;
					end else if (opnd_s1 >= 32'(LOCALS_PER_FRAME)) begin
						status = svm_pkg::ST_BAD_LOCAL;
					end else if (cmd_s1 == svm_pkg::OP_LOAD) begin
						if (sp_full) begin
							status = svm_pkg::ST_STACK_OVER;
						end else begin
							st_we = !sp_empty;
							n_top = local_val;
							n_sp = sp_q + SPW'(1);
							n_ip = ip_p2;
						end
					end else begin
						if (sp_empty) begin
							status = svm_pkg::ST_STACK_UNDER;
						end else begin
							loc_we = 1'b1;
							// Mark the slot written in the current frame's row.
							flg_we = 1'b1;
							flg_wa = depth_m1[FB-1:0];
							flg_wd = flg_row | (LPF'(1) << slot);
							n_top = second;
							n_sp = sp_m1;
							n_ip = ip_p2;
						end
					end
				end
				svm_pkg::OP_JMP: begin
					n_ip = ip_rel;
				end
				svm_pkg::OP_JNZ, svm_pkg::OP_JZ: begin
					if (sp_empty) begin
						status = svm_pkg::ST_STACK_UNDER;
					end else begin
						n_top = second;
						n_sp = sp_m1;
						n_ip = ((top_q != '0) == (cmd_s1 == svm_pkg::OP_JNZ)) ? ip_rel : ip_p2;
					end
				end
				svm_pkg::OP_CALL: begin
					if (depth_q >= DW'(CALL_DEPTH)) begin
						status = svm_pkg::ST_CALL_OVER;
					end else begin
						ret_we = 1'b1;
						flg_we = 1'b1;
						n_depth = depth_q + DW'(1);
						n_ip = opnd_s1[AW-1:0];
					end
				end
				svm_pkg::OP_RET: begin
					if (depth_zero) begin
						status = svm_pkg::ST_CALL_UNDER;
					end else begin
						n_depth = depth_m1;
						n_ip = ret_val;
					end
				end
				svm_pkg::OP_LNOT: begin
					if (sp_empty) begin
						status = svm_pkg::ST_STACK_UNDER;
					end else begin
						n_top = 32'(top_q == '0);
						n_ip = ip_p1;
					end
				end
				svm_pkg::OP_HALT: begin
					status = svm_pkg::ST_HALTED;
				end
				default: begin
					// Two-operand arithmetic and unsigned compares.
					if (sp_lt2) begin
						status = svm_pkg::ST_STACK_UNDER;
					end else begin
						case (cmd_s1)
							svm_pkg::OP_ADD: n_top = second + top_q;
							svm_pkg::OP_SUB: n_top = second - top_q;
							svm_pkg::OP_EQ:  n_top = 32'(second == top_q);
							svm_pkg::OP_LEQ: n_top = 32'(second <= top_q);
							svm_pkg::OP_GEQ: n_top = 32'(second >= top_q);
							svm_pkg::OP_LT:  n_top = 32'(second < top_q);
							default:         n_top = 32'(second > top_q);
						endcase
						n_sp = sp_m1;
						n_ip = ip_p1;
					end
				end
			endcase
		end
		// Halt and every error stop the unit.
		if (status != svm_pkg::ST_NEXT) begin
			n_stopped = 1'b1;
		end
	end

	// Read addresses for the word being accepted, taken from the state the
	// executing instruction leaves behind.
	logic [SPW-1:0] sp_la, sp_la_m2;
	logic [DW-1:0]  depth_la, depth_la_m1;
	assign sp_la       = fire ? n_sp : sp_q;
	assign depth_la    = fire ? n_depth : depth_q;
	assign sp_la_m2    = sp_la - SPW'(2);
	assign depth_la_m1 = depth_la - DW'(1);
	assign st_ra  = sp_la_m2[SA-1:0];
	assign loc_ra = {depth_la_m1[FB-1:0], instr.operand[LB-1:0]};
	assign ret_ra = depth_la_m1[FB-1:0];
	assign flg_ra = depth_la_m1[FB-1:0];

	logic st_wr, loc_wr, ret_wr, flg_wr;
	assign st_wr  = fire && st_we;
	assign loc_wr = fire && loc_we;
	assign ret_wr = fire && ret_we;
	assign flg_wr = fire && flg_we;

	svm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(st_wr), .waddr(st_wa), .wdata(st_wd),
		.re(accept), .raddr(st_ra), .rdata(st_rd)
	);

	svm_ram #(.WIDTH(32), .DEPTH(LOC_DEPTH)) u_locals (
		.clk(clk), .we(loc_wr), .waddr(loc_wa), .wdata(loc_wd),
		.re(accept), .raddr(loc_ra), .rdata(loc_rd)
	);

	svm_ram #(.WIDTH(AW), .DEPTH((CALL_DEPTH > 1) ? CALL_DEPTH : 2)) u_ret (
		.clk(clk), .we(ret_wr), .waddr(ret_wa), .wdata(ret_wd),
		.re(accept), .raddr(ret_ra), .rdata(ret_rd)
	);

	svm_ram #(.WIDTH(LPF), .DEPTH((CALL_DEPTH > 1) ? CALL_DEPTH : 2)) u_flags (
		.clk(clk), .we(flg_wr), .waddr(flg_wa), .wdata(flg_wd),
		.re(accept), .raddr(flg_ra), .rdata(flg_rd)
	);

	// Result fields, cut to the port widths.
	logic [31:0] ip_ext, sp_ext, depth_ext;
	assign ip_ext    = 32'(n_ip);
	assign sp_ext    = 32'(n_sp);
	assign depth_ext = 32'(n_depth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_last_q <= '0;
			ip_q <= '0;
			sp_q <= '0;
			depth_q <= '0;
			stopped_q <= 1'b1;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			st_byp_q <= 1'b0;
			loc_byp_q <= 1'b0;
			ret_byp_q <= 1'b0;
			flg_byp_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				code_last_q <= cfg.data;
			end
			if (fire) begin
				ip_q <= n_ip;
				sp_q <= n_sp;
				depth_q <= n_depth;
				stopped_q <= n_stopped;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
				st_byp_q <= st_wr && (st_wa == st_ra);
				loc_byp_q <= loc_wr && (loc_wa == loc_ra);
				ret_byp_q <= ret_wr && (ret_wa == ret_ra);
				flg_byp_q <= flg_wr && (flg_wa == flg_ra);
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			top_q <= n_top;
			out_status_q <= status;
			out_addr_q <= ip_ext[15:0];
			out_top_q <= (n_sp == '0) ? 32'd0 : n_top;
			out_count_q <= sp_ext[12:0];
			out_depth_q <= depth_ext[6:0];
		end
		if (accept) begin
			cmd_s1 <= instr.command;
			opnd_s1 <= instr.operand;
			st_byp_data_q <= st_wd;
			loc_byp_data_q <= loc_wd;
			ret_byp_data_q <= ret_wd;
			flg_byp_data_q <= flg_wd;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = out_status_q;
	assign result.next_address = out_addr_q;
	assign result.top_value    = out_top_q;
	assign result.stack_count  = out_count_q;
	assign result.frame_depth  = out_depth_q;

	`SVM_ASSERT_NOW(a_ready_when_empty, !valid_s1, instr.ready,
		"execute stage empty but instruction channel not ready")
	`SVM_ASSERT_NOW(a_sp_range, 1'b1, sp_q <= SPW'(STACK_DEPTH),
		"stack pointer beyond stack depth")
	`SVM_ASSERT_NOW(a_depth_range, 1'b1, depth_q <= DW'(CALL_DEPTH),
		"call depth beyond frame count")
	`SVM_ASSERT_NEXT(a_error_stops, fire && (status != svm_pkg::ST_NEXT), stopped_q,
		"error or halt did not stop the unit")

endmodule

>>> design/svm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module svm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the stack machine execute unit: directed and random
// instruction streams checked against a behavioral predictor of the machine.
// Depends on svm_pkg, the channel interfaces in svm_if.sv and the unit's RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_WORDS = 4096;
	localparam int FRAME_LIMIT = 64;
	localparam int LOCAL_SLOTS = 16;
	localparam logic [4:0] OP_FIRST_INVALID = 5'd23;
	localparam logic [31:0] UNSET_LOCAL = 32'hFFFF_FFFF;

	// One result word as the unit reports it.
	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] next_address;
		logic [31:0] top_value;
		logic [12:0] stack_count;
		logic [6:0]  frame_depth;
	} vm_result_t;

	logic clk;
	logic arst_n;

	svm_cmd_if instr_ch();
	svm_res_if res_ch();
	svm_cfg_if cfg_ch();

	stack_vm_execute_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Free-running clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Architectural state of the machine as the predictor sees it.
	logic [15:0] vm_code_last;
	logic [15:0] vm_ip;
	int          vm_sp;
	int          vm_depth;
	bit          vm_stopped;
	logic [31:0] vm_stack [STACK_WORDS];
	logic [15:0] vm_ret_addr [FRAME_LIMIT];
	logic [31:0] vm_locals [FRAME_LIMIT][LOCAL_SLOTS];
	bit          vm_local_set [FRAME_LIMIT][LOCAL_SLOTS];

	// Expected result words, oldest first.
	vm_result_t pending_results[$];

	int errors;
	int words_sent;
	int words_checked;
	int status_seen [16];

	// Handshake pacing. When gaps_enabled is clear both sides run flat out;
	// ready_hold forces a long receiver stall that the receiver counts down.
	bit gaps_enabled;
	int ready_hold;
	int ready_stall;

	// Executes one instruction on the predicted state and returns the result
	// word it must produce. Errors leave everything but the stopped flag alone.
	function automatic vm_result_t execute_predict(logic [4:0] cmd, logic [31:0] opnd);
		vm_result_t r;
		logic [3:0]  st;
		logic [15:0] ip;
		int          sp;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] v;
		st = svm_pkg::ST_NEXT;
		ip = vm_ip;
		sp = vm_sp;
		if (cmd == svm_pkg::OP_START) begin
			ip = opnd[15:0];
			sp = 0;
			vm_depth = 1;
			vm_ret_addr[0] = '0;
			for (int i = 0; i < LOCAL_SLOTS; i++) vm_local_set[0][i] = 1'b0;
			vm_stopped = 1'b0;
		end else if (vm_stopped) begin
			st = svm_pkg::ST_HALTED;
		end else if (cmd == svm_pkg::OP_PUSH_ARG) begin
			if (sp >= STACK_WORDS) begin
				st = svm_pkg::ST_STACK_OVER;
			end else begin
				vm_stack[sp] = opnd;
				sp++;
			end
		end else if (cmd >= OP_FIRST_INVALID) begin
			st = svm_pkg::ST_BAD_OPCODE;
		end else if (ip > vm_code_last) begin
			st = svm_pkg::ST_BAD_ADDR;
		end else begin
			case (cmd)
				svm_pkg::OP_NOP: ip += 16'd1;
				svm_pkg::OP_PUSH: begin
					if (sp >= STACK_WORDS) st = svm_pkg::ST_STACK_OVER;
					else begin
						vm_stack[sp] = opnd;
						sp++;
						ip += 16'd2;
					end
				end
				svm_pkg::OP_POP: begin
					if (sp == 0) st = svm_pkg::ST_STACK_UNDER;
					else begin
						sp--;
						ip += 16'd1;
					end
				end
				svm_pkg::OP_DUP: begin
					if (sp == 0) st = svm_pkg::ST_STACK_UNDER;
					else if (sp >= STACK_WORDS) st = svm_pkg::ST_STACK_OVER;
					else begin
						vm_stack[sp] = vm_stack[sp-1];
						sp++;
						ip += 16'd1;
					end
				end
				svm_pkg::OP_SWAP: begin
					if (sp < 2) st = svm_pkg::ST_STACK_UNDER;
					else begin
						a = vm_stack[sp-1];
						vm_stack[sp-1] = vm_stack[sp-2];
						vm_stack[sp-2] = a;
						ip += 16'd1;
					end
				end
				svm_pkg::OP_LOAD, svm_pkg::OP_STORE: begin
					// Frame presence first, then the index, then the stack.
					if (vm_depth == 0) st = svm_pkg::ST_CALL_UNDER;
					else if (opnd >= LOCAL_SLOTS) st = svm_pkg::ST_BAD_LOCAL;
					else if (cmd == svm_pkg::OP_LOAD) begin
						if (sp >= STACK_WORDS) st = svm_pkg::ST_STACK_OVER;
						else begin
							vm_stack[sp] = vm_local_set[vm_depth-1][opnd[3:0]] ?
								vm_locals[vm_depth-1][opnd[3:0]] : UNSET_LOCAL;
							sp++;
							ip += 16'd2;
						end
					end else begin
						if (sp == 0) st = svm_pkg::ST_STACK_UNDER;
						else begin
							sp--;
							vm_locals[vm_depth-1][opnd[3:0]] = vm_stack[sp];
							vm_local_set[vm_depth-1][opnd[3:0]] = 1'b1;
							ip += 16'd2;
						end
					end
				end
				svm_pkg::OP_JMP: ip += opnd[15:0];
				svm_pkg::OP_JNZ, svm_pkg::OP_JZ: begin
					if (sp == 0) st = svm_pkg::ST_STACK_UNDER;
					else begin
						sp--;
						a = vm_stack[sp];
						if ((a != 0) == (cmd == svm_pkg::OP_JNZ)) ip += opnd[15:0];
						else ip += 16'd2;
					end
				end
				svm_pkg::OP_CALL: begin
					if (vm_depth >= FRAME_LIMIT) st = svm_pkg::ST_CALL_OVER;
					else begin
						vm_ret_addr[vm_depth] = ip + 16'd2;
						for (int i = 0; i < LOCAL_SLOTS; i++) vm_local_set[vm_depth][i] = 1'b0;
						vm_depth++;
						ip = opnd[15:0];
					end
				end
				svm_pkg::OP_RET: begin
					if (vm_depth == 0) st = svm_pkg::ST_CALL_UNDER;
					else begin
						vm_depth--;
						ip = vm_ret_addr[vm_depth];
					end
				end
				svm_pkg::OP_LNOT: begin
					if (sp == 0) st = svm_pkg::ST_STACK_UNDER;
					else begin
						vm_stack[sp-1] = (vm_stack[sp-1] == 0) ? 32'd1 : 32'd0;
						ip += 16'd1;
					end
				end
				svm_pkg::OP_HALT: st = svm_pkg::ST_HALTED;
				default: begin
					// Two-operand arithmetic and unsigned compares.
					if (sp < 2) st = svm_pkg::ST_STACK_UNDER;
					else begin
						b = vm_stack[sp-1];
						a = vm_stack[sp-2];
						case (cmd)
							svm_pkg::OP_ADD: v = a + b;
							svm_pkg::OP_SUB: v = a - b;
							svm_pkg::OP_EQ:  v = {31'd0, a == b};
							svm_pkg::OP_LEQ: v = {31'd0, a <= b};
							svm_pkg::OP_GEQ: v = {31'd0, a >= b};
							svm_pkg::OP_LT:  v = {31'd0, a < b};
							default: v = {31'd0, a > b};
						endcase
						sp--;
						vm_stack[sp-1] = v;
						ip += 16'd1;
					end
				end
			endcase
		end
		if (st != svm_pkg::ST_NEXT) begin
			vm_stopped = 1'b1;
		end else begin
			vm_ip = ip;
			vm_sp = sp;
		end
		r.status = st;
		r.next_address = vm_ip;
		r.top_value = (vm_sp > 0) ? vm_stack[vm_sp-1] : 32'd0;
		r.stack_count = vm_sp[12:0];
		r.frame_depth = vm_depth[6:0];
		return r;
	endfunction

	// Sends one instruction word, predicting its result before it goes out.
	// Valid stays high across back-to-back words and only drops for a gap.
	task automatic send_instr(logic [4:0] cmd, logic [31:0] opnd);
		int gap;
		gap = gaps_enabled ? $urandom_range(0, 18) : 0;
		pending_results.push_back(execute_predict(cmd, opnd));
		@(negedge clk);
		if (gap > 0) begin
			instr_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.command <= cmd;
		instr_ch.operand <= opnd;
		@(posedge clk);
		while (!instr_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	// Lowers valid and waits until every predicted result has come back,
	// then lets the pipeline settle.
	task automatic drain();
		@(negedge clk);
		instr_ch.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (6) @(posedge clk);
	endtask

	// Writes code_last; only called with the unit drained.
	task automatic write_code_last(logic [15:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		vm_code_last = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Receiver pacing: a forced hold first, then the stall drawn per word.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				ready_hold--;
				res_ch.ready <= 1'b0;
			end else if (ready_stall > 0) begin
				ready_stall--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Result checker: each accepted word is compared against the oldest
	// prediction, field by field.
	always @(posedge clk) begin
		vm_result_t exp_r;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with no prediction pending: status %0d", res_ch.status);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (res_ch.status !== exp_r.status) begin
					$error("status: expected %0d actual %0d", exp_r.status, res_ch.status);
					errors++;
				end
				if (res_ch.next_address !== exp_r.next_address) begin
					$error("next_address: expected %h actual %h",
						exp_r.next_address, res_ch.next_address);
					errors++;
				end
				if (res_ch.top_value !== exp_r.top_value) begin
					$error("top_value: expected %h actual %h", exp_r.top_value, res_ch.top_value);
					errors++;
				end
				if (res_ch.stack_count !== exp_r.stack_count) begin
					$error("stack_count: expected %0d actual %0d",
						exp_r.stack_count, res_ch.stack_count);
					errors++;
				end
				if (res_ch.frame_depth !== exp_r.frame_depth) begin
					$error("frame_depth: expected %0d actual %0d",
						exp_r.frame_depth, res_ch.frame_depth);
					errors++;
				end
				status_seen[exp_r.status]++;
			end
			words_checked++;
			ready_stall = gaps_enabled ? $urandom_range(0, 18) : 0;
		end
	end

	// Before any start the unit is stopped and answers halted to everything.
	task automatic test_stopped_after_reset();
		send_instr(svm_pkg::OP_PUSH, 32'h1234_5678);
		send_instr(svm_pkg::OP_HALT, 32'd0);
		send_instr(svm_pkg::OP_RET, 32'd0);
		drain();
		write_code_last(16'hFFFF);
	endtask

	// Stack shuffling, arithmetic with extreme values and unsigned compares.
	task automatic test_arith_and_stack();
		send_instr(svm_pkg::OP_START, 32'd0);
		send_instr(svm_pkg::OP_POP, 32'd0);          // empty stack underflows
		send_instr(svm_pkg::OP_START, 32'hFFFF_0010);
		send_instr(svm_pkg::OP_PUSH, 32'hFFFF_FFFF);
		send_instr(svm_pkg::OP_PUSH_ARG, 32'd1);
		send_instr(svm_pkg::OP_ADD, 32'd0);          // wraps to zero
		send_instr(svm_pkg::OP_LNOT, 32'd0);
		send_instr(svm_pkg::OP_PUSH, 32'h8000_0000);
		send_instr(svm_pkg::OP_DUP, 32'd0);
		send_instr(svm_pkg::OP_SWAP, 32'd0);
		send_instr(svm_pkg::OP_SUB, 32'd0);
		for (logic [4:0] op = svm_pkg::OP_EQ; op <= svm_pkg::OP_GT; op++) begin
			send_instr(svm_pkg::OP_PUSH, 32'hFFFF_FFFE);
			send_instr(svm_pkg::OP_PUSH, 32'h7FFF_FFFF);
			send_instr(op, 32'd0);
		end
		send_instr(svm_pkg::OP_NOP, 32'd0);
		send_instr(svm_pkg::OP_POP, 32'd0);
		send_instr(svm_pkg::OP_HALT, 32'd0);
		send_instr(svm_pkg::OP_NOP, 32'd0);          // halted until the next start
		send_instr(svm_pkg::OP_START, 32'd5);
		send_instr(5'd31, 32'd0);                    // invalid opcode
		send_instr(svm_pkg::OP_START, 32'd5);
		send_instr(OP_FIRST_INVALID, 32'd0);
		drain();
	endtask

	// Locals: unwritten reads, store and reload, index range and missing frame.
	task automatic test_locals();
		send_instr(svm_pkg::OP_START, 32'd0);
		send_instr(svm_pkg::OP_LOAD, 32'd3);         // unwritten local reads all ones
		send_instr(svm_pkg::OP_STORE, 32'd15);
		send_instr(svm_pkg::OP_LOAD, 32'd15);
		send_instr(svm_pkg::OP_STORE, 32'd0);
		send_instr(svm_pkg::OP_STORE, 32'd0);        // nothing left to store
		send_instr(svm_pkg::OP_START, 32'd0);
		send_instr(svm_pkg::OP_LOAD, 32'd16);        // index out of range
		send_instr(svm_pkg::OP_START, 32'd0);
		send_instr(svm_pkg::OP_STORE, 32'hFFFF_FFFF);
		send_instr(svm_pkg::OP_START, 32'd0);
		send_instr(svm_pkg::OP_RET, 32'd0);          // leaves no frame at all
		send_instr(svm_pkg::OP_LOAD, 32'd0);
		send_instr(svm_pkg::OP_START, 32'd0);
		send_instr(svm_pkg::OP_RET, 32'd0);
		send_instr(svm_pkg::OP_STORE, 32'd0);
		drain();
	endtask

	// Jumps with both branch senses, negative offsets, call and return.
	task automatic test_control_flow();
		send_instr(svm_pkg::OP_START, 32'd100);
		send_instr(svm_pkg::OP_JMP, 32'hFFFF_FFF0);
		send_instr(svm_pkg::OP_PUSH, 32'd0);
		send_instr(svm_pkg::OP_JZ, 32'd8);
		send_instr(svm_pkg::OP_PUSH, 32'd0);
		send_instr(svm_pkg::OP_JNZ, 32'd8);
		send_instr(svm_pkg::OP_PUSH, 32'd7);
		send_instr(svm_pkg::OP_JNZ, 32'hFFFF_FFFC);
		send_instr(svm_pkg::OP_PUSH, 32'd7);
		send_instr(svm_pkg::OP_JZ, 32'd8);
		send_instr(svm_pkg::OP_JZ, 32'd8);           // empty stack underflows
		send_instr(svm_pkg::OP_START, 32'hFFFE);
		send_instr(svm_pkg::OP_CALL, 32'h0001_0200);
		send_instr(svm_pkg::OP_STORE, 32'd1);        // stack empty in the new frame
		send_instr(svm_pkg::OP_START, 32'hFFFE);
		send_instr(svm_pkg::OP_CALL, 32'd300);
		send_instr(svm_pkg::OP_RET, 32'd0);          // return address wrapped past the top
		send_instr(svm_pkg::OP_RET, 32'd0);
		send_instr(svm_pkg::OP_RET, 32'd0);          // call underflow
		send_instr(svm_pkg::OP_JMP, 32'd2);          // halted after the underflow
		send_instr(svm_pkg::OP_START, 32'd0);
		send_instr(svm_pkg::OP_JMP, 32'h8000_0000);
		drain();
	endtask

	// Addresses above code_last are refused except for start and push_argument.
	task automatic test_code_range();
		write_code_last(16'd10);
		send_instr(svm_pkg::OP_START, 32'd11);
		send_instr(svm_pkg::OP_PUSH_ARG, 32'hA5A5_A5A5);
		send_instr(svm_pkg::OP_NOP, 32'd0);
		send_instr(svm_pkg::OP_START, 32'd10);
		send_instr(svm_pkg::OP_NOP, 32'd0);
		send_instr(svm_pkg::OP_NOP, 32'd0);
		drain();
		write_code_last(16'd0);
		send_instr(svm_pkg::OP_START, 32'd0);
		send_instr(svm_pkg::OP_JMP, 32'd0);
		send_instr(svm_pkg::OP_NOP, 32'd0);
		send_instr(svm_pkg::OP_NOP, 32'd0);
		drain();
		write_code_last(16'hFFFF);
	endtask

	// Fills the stack to the last word with pushes, a dup and a load, then
	// overflows it. A long receiver hold at the start backs the unit up into
	// its input.
	task automatic test_stack_full();
		gaps_enabled = 1'b0;
		send_instr(svm_pkg::OP_START, 32'd0);
		ready_hold = 300;
		for (int i = 0; i < STACK_WORDS - 2; i++) send_instr(svm_pkg::OP_PUSH_ARG, $urandom());
		send_instr(svm_pkg::OP_DUP, 32'd0);
		send_instr(svm_pkg::OP_LOAD, 32'd2);         // unwritten local fills the last word
		send_instr(svm_pkg::OP_PUSH, 32'd3);         // stack overflow
		send_instr(svm_pkg::OP_PUSH_ARG, 32'd1);     // stopped after the overflow
		drain();
		gaps_enabled = 1'b1;
	endtask

	// Nests calls up to the frame limit and unwinds them again.
	task automatic test_call_depth();
		send_instr(svm_pkg::OP_START, 32'd0);
		for (int i = 1; i < FRAME_LIMIT; i++) begin
			send_instr(svm_pkg::OP_CALL, 32'd4 * i);
			if (i % 8 == 0) send_instr(svm_pkg::OP_STORE, 32'd0);
		end
		send_instr(svm_pkg::OP_CALL, 32'd0);         // halted after the store underflow
		send_instr(svm_pkg::OP_START, 32'd0);
		for (int i = 1; i < FRAME_LIMIT; i++) send_instr(svm_pkg::OP_CALL, 32'd4 * i);
		for (int i = 0; i < FRAME_LIMIT; i++) send_instr(svm_pkg::OP_RET, 32'd0);
		send_instr(svm_pkg::OP_RET, 32'd0);
		drain();
	endtask

	// Picks a random instruction, mostly well formed, that keeps a started
	// program alive; a stopped machine is usually restarted.
	task automatic send_random_instr();
		int pick;
		logic [4:0]  cmd;
		logic [31:0] opnd;
		pick = $urandom_range(0, 99);
		opnd = $urandom();
		if (vm_stopped && $urandom_range(0, 9) != 0) begin
			cmd = svm_pkg::OP_START;
			opnd = $urandom_range(0, vm_code_last);
		end else if (pick < 3) begin
			cmd = svm_pkg::OP_START;
		end else if (pick < 5) begin
			cmd = 5'($urandom_range(OP_FIRST_INVALID, 31));
		end else if (pick < 7) begin
			cmd = svm_pkg::OP_HALT;
		end else if (pick < 12) begin
			cmd = svm_pkg::OP_RET;
		end else if (pick < 17) begin
			cmd = svm_pkg::OP_CALL;
			if ($urandom_range(0, 3) != 0) opnd = $urandom_range(0, vm_code_last);
		end else if (pick < 26) begin
			cmd = 5'($urandom_range(svm_pkg::OP_JMP, svm_pkg::OP_JZ));
			if ($urandom_range(0, 3) != 0) opnd = 32'($signed($urandom_range(0, 16)) - 8);
		end else if (pick < 38) begin
			cmd = ($urandom_range(0, 1) != 0) ? svm_pkg::OP_LOAD : svm_pkg::OP_STORE;
			if ($urandom_range(0, 19) != 0) opnd = $urandom_range(0, LOCAL_SLOTS - 1);
		end else if (pick < 56) begin
			cmd = ($urandom_range(0, 1) != 0) ? svm_pkg::OP_PUSH : svm_pkg::OP_PUSH_ARG;
			case ($urandom_range(0, 3))
				0: opnd = 32'd0;
				1: opnd = 32'd1;
				2: opnd = UNSET_LOCAL;
				default: ;
			endcase
		end else begin
			case ($urandom_range(0, 5))
				0: cmd = svm_pkg::OP_NOP;
				1: cmd = svm_pkg::OP_POP;
				2: cmd = svm_pkg::OP_DUP;
				3: cmd = svm_pkg::OP_SWAP;
				4: cmd = svm_pkg::OP_LNOT;
				default: cmd = 5'($urandom_range(svm_pkg::OP_ADD, svm_pkg::OP_GT));
			endcase
		end
		send_instr(cmd, opnd);
	endtask

	// Random programs over several code_last settings, idling switched on and
	// off in stretches, with a full drain between settings.
	task automatic test_random();
		logic [15:0] limits [5];
		limits = '{16'hFFFF, 16'd0, 16'h8000, 16'($urandom()), 16'hFFFF};
		foreach (limits[k]) begin
			write_code_last(limits[k]);
			for (int n = 0; n < 200; n++) begin
				if (n % 50 == 0) gaps_enabled = ($urandom_range(0, 3) != 0);
				send_random_instr();
			end
			drain();
		end
		gaps_enabled = 1'b1;
	endtask

	initial begin
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		ready_hold = 0;
		ready_stall = 0;
		gaps_enabled = 1'b1;
		foreach (status_seen[i]) status_seen[i] = 0;
		vm_code_last = '0;
		vm_ip = '0;
		vm_sp = 0;
		vm_depth = 0;
		vm_stopped = 1'b1;
		foreach (vm_local_set[f, i]) vm_local_set[f][i] = 1'b0;
		arst_n = 1'b0;
		instr_ch.valid = 1'b0;
		instr_ch.command = '0;
		instr_ch.operand = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_stopped_after_reset();
		test_arith_and_stack();
		test_locals();
		test_control_flow();
		test_code_range();
		test_stack_full();
		test_call_depth();
		test_random();

		drain();
		$display("Ran %0d instruction words, %0d results checked, %0d errors.",
			words_sent, words_checked, errors);
		$display("Results by status: next %0d, halted %0d, underflow %0d, overflow %0d, bad address %0d.",
			status_seen[svm_pkg::ST_NEXT], status_seen[svm_pkg::ST_HALTED],
			status_seen[svm_pkg::ST_STACK_UNDER], status_seen[svm_pkg::ST_STACK_OVER],
			status_seen[svm_pkg::ST_BAD_ADDR]);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
